/* design/rfp_pkg.sv */
// rfp_pkg: shared types and constants of the radar frame parser.
// Used by rfp_front, rfp_queue, rfp_back and radar_frame_parser_top; no dependencies.
package rfp_pkg;

	localparam int MAX_TARGETS = 8;
	localparam int STORE_DEPTH = 4 + 4 * MAX_TARGETS;
	localparam int OFF_W       = $clog2(STORE_DEPTH);
	localparam int ADDR_W      = $clog2(2 * STORE_DEPTH);
	localparam int N_W         = $clog2(MAX_TARGETS + 1);
	localparam int Q_DEPTH     = 2;
	localparam int Q_PTR_W     = $clog2(Q_DEPTH);
	localparam int Q_CNT_W     = $clog2(Q_DEPTH + 1);
	localparam int OUT_W       = 48;

	localparam logic [7:0] SYNC_RESET = 8'h5A;
	localparam logic [7:0] TYPE_RESET = 8'd7;

	// register indexes of the configuration port
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_SYNC = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TYPE = 1'd1;

	// result status codes
	localparam logic [1:0] ST_RECORD = 2'd0;
	localparam logic [1:0] ST_EMPTY  = 2'd1;
	localparam logic [1:0] ST_BADSUM = 2'd2;
	localparam logic [1:0] ST_SHORT  = 2'd3;

	// work handed from the parser to the emitter
	typedef struct packed {
		logic [1:0]     status;
		logic [N_W-1:0] n;
		logic           bank;
	} job_t;

	// record store write port
	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] addr;
		logic [7:0]        data;
	} wr_t;

	// emitter has finished with a record bank
	typedef struct packed {
		logic valid;
		logic bank;
	} done_t;

	function automatic logic [ADDR_W-1:0] bank_base(input logic bank);
		return bank ? ADDR_W'(STORE_DEPTH) : '0;
	endfunction

endpackage

/* design/rfp_front.sv */
// rfp_front: byte parser; hunts for sync, checks the frame sum, writes records into
// the store, queues a job per frame with a bad sum or the report type. Depends on rfp_pkg.
module rfp_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [rfp_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [7:0]                    cfg_data,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [7:0]                    rx_byte,
	input  logic                          q_full,
	output logic                          push,
	output rfp_pkg::job_t                 job,
	output rfp_pkg::wr_t                  wr,
	input  rfp_pkg::done_t                done
);

	typedef enum logic [4:0] {
		PH_HUNT    = 5'b00001,
		PH_LEN     = 5'b00010,
		PH_TYPE    = 5'b00100,
		PH_PAYLOAD = 5'b01000,
		PH_CHECK   = 5'b10000
	} phase_t;

	phase_t     phase_q;
	logic [7:0] sync_q, rtype_q;
	logic       wb_q;
	logic [1:0] busy_q;
	logic [7:0] len_q, kind_q, sum_q, pc_q, cnt_lo_q, cnt_hi_q;

	logic       acc;
	logic [7:0] sum_next, pc_next, len_m1, fit;
	logic [15:0] count;
	logic [rfp_pkg::N_W-1:0] cap, n;
	logic       job_any;

	assign s_tready = !((phase_q == PH_PAYLOAD) && busy_q[wb_q])
		&& !((phase_q == PH_CHECK) && q_full);
	assign acc      = s_tvalid && s_tready;
	assign sum_next = sum_q + rx_byte;
	assign pc_next  = pc_q + 8'd1;
	assign len_m1   = len_q - 8'd1;
	assign count    = {cnt_hi_q, cnt_lo_q};
	assign cap      = (count > 16'(rfp_pkg::MAX_TARGETS))
		? rfp_pkg::N_W'(rfp_pkg::MAX_TARGETS) : count[rfp_pkg::N_W-1:0];
	assign fit      = (len_m1 - 8'd4) >> 2;
	assign n        = (fit < 8'(cap)) ? fit[rfp_pkg::N_W-1:0] : cap;

	// check byte outcome
	always_comb begin
		job_any    = 1'b1;
		job.status = rfp_pkg::ST_RECORD;
		job.n      = n;
		job.bank   = wb_q;
		priority if (rx_byte != sum_q) begin
			job.status = rfp_pkg::ST_BADSUM;
		end else if (kind_q != rtype_q) begin
			job_any = 1'b0;
		end else if (len_m1 < 8'd4) begin
			job.status = rfp_pkg::ST_SHORT;
		end else if (n == '0) begin
			job.status = rfp_pkg::ST_EMPTY;
		end else begin
			job.status = rfp_pkg::ST_RECORD;
		end
	end

	assign push = acc && (phase_q == PH_CHECK) && job_any;

	always_comb begin
		wr.we   = acc && (phase_q == PH_PAYLOAD) && (pc_q >= 8'd4)
			&& (pc_q < 8'(rfp_pkg::STORE_DEPTH));
		wr.addr = rfp_pkg::bank_base(wb_q)
			+ rfp_pkg::ADDR_W'(pc_q[rfp_pkg::OFF_W-1:0]);
		wr.data = rx_byte;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
			sync_q  <= rfp_pkg::SYNC_RESET;
			rtype_q <= rfp_pkg::TYPE_RESET;
			wb_q    <= 1'b0;
			busy_q  <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					rfp_pkg::REG_SYNC: sync_q  <= cfg_data;
					rfp_pkg::REG_TYPE: rtype_q <= cfg_data;
					default: ;
				endcase
			end
			if (done.valid)
				busy_q[done.bank] <= 1'b0;
			if (push && job.status == rfp_pkg::ST_RECORD) begin
				busy_q[wb_q] <= 1'b1;
				wb_q         <= !wb_q;
			end
			if (acc) begin
				unique case (phase_q)
					PH_HUNT:    if (rx_byte == sync_q) phase_q <= PH_LEN;
					PH_LEN:     phase_q <= (rx_byte == 8'd0) ? PH_HUNT : PH_TYPE;
					PH_TYPE:    phase_q <= (len_q <= 8'd1) ? PH_CHECK : PH_PAYLOAD;
					PH_PAYLOAD: if (pc_next >= len_m1) phase_q <= PH_CHECK;
					PH_CHECK:   phase_q <= PH_HUNT;
					default:    phase_q <= PH_HUNT;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			unique case (phase_q)
				PH_HUNT: sum_q <= rx_byte;
				PH_LEN: begin
					len_q <= rx_byte;
					sum_q <= sum_next;
					pc_q  <= '0;
				end
				PH_TYPE: begin
					kind_q <= rx_byte;
					sum_q  <= sum_next;
				end
				PH_PAYLOAD: begin
					if (pc_q == 8'd0) cnt_lo_q <= rx_byte;
					if (pc_q == 8'd1) cnt_hi_q <= rx_byte;
					sum_q <= sum_next;
					pc_q  <= pc_next;
				end
				default: ;
			endcase
		end
	end

endmodule

/* design/rfp_queue.sv */
// rfp_queue: short job queue between parser and emitter.
// Depends on rfp_pkg.
module rfp_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  rfp_pkg::job_t push_job,
	output logic          full,
	input  logic          pop,
	output logic          avail,
	output rfp_pkg::job_t head
);

	rfp_pkg::job_t               slot_q [rfp_pkg::Q_DEPTH];
	logic [rfp_pkg::Q_PTR_W-1:0] wp_q, rp_q;
	logic [rfp_pkg::Q_CNT_W-1:0] cnt_q;

	assign full  = (cnt_q == rfp_pkg::Q_CNT_W'(rfp_pkg::Q_DEPTH));
	assign avail = (cnt_q != '0);
	assign head  = slot_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wp_q <= (wp_q == rfp_pkg::Q_PTR_W'(rfp_pkg::Q_DEPTH - 1))
					? '0 : wp_q + 1'b1;
			if (pop)
				rp_q <= (rp_q == rfp_pkg::Q_PTR_W'(rfp_pkg::Q_DEPTH - 1))
					? '0 : rp_q + 1'b1;
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			slot_q[wp_q] <= push_job;
	end

endmodule

/* design/rfp_back.sv */
// rfp_back: emitter; holds the two-bank record store, reads records back and
// drives the result register. Depends on rfp_pkg.
module rfp_back (
	input  logic                         clk,
	input  logic                         arst_n,
	input  rfp_pkg::wr_t                 wr,
	input  logic                         avail,
	input  rfp_pkg::job_t                head,
	output logic                         pop,
	output rfp_pkg::done_t               done,
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [rfp_pkg::OUT_W-1:0]    m_tdata,
	output logic                         m_tlast
);

	typedef enum logic [2:0] {
		B_IDLE = 3'b001,
		B_LOAD = 3'b010,
		B_SEND = 3'b100
	} bstate_t;

	logic [7:0] mem [2 * rfp_pkg::STORE_DEPTH];
	logic [7:0] rd_data_q;
	logic [rfp_pkg::ADDR_W-1:0] rd_addr;

	bstate_t                 state_q;
	rfp_pkg::job_t           job_q;
	logic [rfp_pkg::N_W-1:0] idx_q;
	logic [2:0]              rd_cnt_q;
	logic [7:0]              rec_q [3];

	logic       m_valid_q, last_q;
	logic [1:0] st_q;
	logic [2:0] oidx_q;
	logic [3:0] otot_q;
	logic [7:0] range_q, angle_q, speed_q, id_q;
	logic       take, rec_last;

	assign rd_addr = rfp_pkg::bank_base(job_q.bank) + rfp_pkg::ADDR_W'(4)
		+ rfp_pkg::ADDR_W'({idx_q, rd_cnt_q[1:0]});

	always_ff @(posedge clk) begin
		if (wr.we)
			mem[wr.addr] <= wr.data;
		rd_data_q <= mem[rd_addr];
	end

	assign take     = m_valid_q && m_tready;
	assign rec_last = (idx_q + 1'b1 == job_q.n);
	assign pop      = (state_q == B_IDLE) && avail;
	assign done.valid = (state_q == B_SEND) && take && last_q
		&& (job_q.status == rfp_pkg::ST_RECORD);
	assign done.bank  = job_q.bank;

	assign m_tvalid = m_valid_q;
	assign m_tlast  = last_q;
	assign m_tdata  = {7'd0, id_q, speed_q, angle_q, range_q, otot_q, oidx_q, st_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= B_IDLE;
			m_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				B_IDLE: if (avail) begin
					if (head.status == rfp_pkg::ST_RECORD) begin
						state_q <= B_LOAD;
					end else begin
						m_valid_q <= 1'b1;
						state_q   <= B_SEND;
					end
				end
				B_LOAD: if (rd_cnt_q == 3'd4) begin
					m_valid_q <= 1'b1;
					state_q   <= B_SEND;
				end
				B_SEND: if (take) begin
					m_valid_q <= 1'b0;
					state_q   <= last_q ? B_IDLE : B_LOAD;
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			B_IDLE: begin
				job_q    <= head;
				idx_q    <= '0;
				rd_cnt_q <= '0;
				st_q     <= head.status;
				oidx_q   <= '0;
				otot_q   <= '0;
				range_q  <= '0;
				angle_q  <= '0;
				speed_q  <= '0;
				id_q     <= '0;
				last_q   <= 1'b1;
			end
			B_LOAD: begin
				// read data is registered, so it arrives in the cycle after its address
				if (rd_cnt_q != 3'd0 && rd_cnt_q != 3'd4)
					rec_q[rd_cnt_q[1:0] - 2'd1] <= rd_data_q;
				if (rd_cnt_q == 3'd4) begin
					st_q    <= rfp_pkg::ST_RECORD;
					oidx_q  <= idx_q[2:0];
					otot_q  <= 4'(job_q.n);
					range_q <= rec_q[0];
					angle_q <= rec_q[1];
					speed_q <= rec_q[2];
					id_q    <= rd_data_q;
					last_q  <= rec_last;
				end else begin
					rd_cnt_q <= rd_cnt_q + 3'd1;
				end
			end
			B_SEND: if (take) begin
				idx_q    <= idx_q + 1'b1;
				rd_cnt_q <= '0;
			end
			default: ;
		endcase
	end

endmodule

/* design/radar_frame_parser_top.sv */
// radar_frame_parser_top: top level of the radar frame parser.
// Depends on rfp_pkg, rfp_front, rfp_queue and rfp_back.
//
// s_* carries received serial bytes, one per transfer; m_* carries results.
// Frame: sync, length, type, length-1 payload bytes, 8-bit sum of all before.
// cfg_we/cfg_index/cfg_data write sync_byte (index 0) or report_type (1).
// Header bytes are always taken. A check byte is taken once
// the two-entry job queue has room; a payload byte is held off while the
// emitter still reads the record bank that the byte would overwrite.
// A status result (checksum error, short or empty report) passes from the job
// queue straight into the result register. Records are read from the store one
// byte per cycle and then registered as a result; the next record is read
// after each transfer is taken.
// Parsing of the next frame goes on meanwhile, into the other record bank.
// When m_tready is low the result register holds; the parser keeps taking
// bytes until the queue or the bank it needs is occupied.
// Reset clears the parser to sync hunt, loads the register defaults (0x5A, 7),
// empties the queue and drops m_tvalid. The record store is not cleared.
module radar_frame_parser_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [rfp_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [7:0]                    cfg_data,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [7:0]                    s_tdata,   // [7:0] rx_byte
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// [1:0] status, [4:2] target_index, [8:5] target_total, [16:9] range_m,
	// [24:17] bearing, [32:25] velocity, [40:33] object_id, [47:41] zero
	output logic [rfp_pkg::OUT_W-1:0]     m_tdata,
	output logic                          m_tlast    // last
);

	logic           push, q_full, pop, avail;
	rfp_pkg::job_t  job, head;
	rfp_pkg::wr_t   wr;
	rfp_pkg::done_t done;

	rfp_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.rx_byte  (s_tdata),
		.q_full   (q_full),
		.push     (push),
		.job      (job),
		.wr       (wr),
		.done     (done)
	);

	rfp_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_job(job),
		.full    (q_full),
		.pop     (pop),
		.avail   (avail),
		.head    (head)
	);

	rfp_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (wr),
		.avail   (avail),
		.head    (head),
		.pop     (pop),
		.done    (done),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tlast (m_tlast)
	);

endmodule
